/* hdl/pr32_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// pr32_pkg
// Shared types and constants of the 3:2 polyphase resampler: kernel size,
// coefficient ROM, scheduling offsets and the control structs between blocks.
// ============================================================================
package pr32_pkg;

    localparam int TAPS        = 23;
    localparam int TAP_W       = 5;
    localparam int PHASES      = 2;
    localparam int ROM_BITS    = 18;
    localparam int GUARD_BITS  = 5;
    localparam int ROUND_TAP   = TAPS + 1;
    localparam int LAG         = 13;
    localparam int AGE_OFFSET  = 9;
    localparam int MAX_RESULTS = 12;
    localparam int CNT_W       = 4;
    localparam int OUT_W       = 16;

    localparam logic signed [ROM_BITS-1:0] COEF_TABLE [PHASES][TAPS] = '{
        '{  18'sd0,      18'sd0,      -18'sd141,   18'sd692,    -18'sd226,
           -18'sd2847,   18'sd5603,   -18'sd659,   -18'sd15592,  18'sd35469,
            18'sd86508,  18'sd35469,  -18'sd15592, -18'sd659,    18'sd5603,
           -18'sd2847,  -18'sd226,     18'sd692,   -18'sd141,    18'sd0,
            18'sd0,      18'sd0,       18'sd0 },
        '{  18'sd0,      18'sd0,       18'sd0,     -18'sd48,     18'sd64,
            18'sd950,   -18'sd2353,    18'sd443,    18'sd6672,  -18'sd12263,
            18'sd816,    18'sd71288,   18'sd71288,  18'sd816,   -18'sd12263,
            18'sd6672,   18'sd443,    -18'sd2353,   18'sd950,    18'sd64,
           -18'sd48,     18'sd0,       18'sd0 }
    };

    typedef struct packed {
        logic             clear;
        logic             issue;
        logic             round;
        logic             phase;
        logic [TAP_W-1:0] tap;
    } mac_ctrl_t;

    typedef struct packed {
        logic             shift;
        logic             clear;
        logic             rd_en;
        logic [TAP_W-1:0] rd_age;
    } taps_ctrl_t;

    function automatic logic signed [ROM_BITS-1:0] coef_rom(
        input logic             phase,
        input logic [TAP_W-1:0] tap
    );
        logic signed [ROM_BITS-1:0] val;
        val = '0;
        if (tap < TAP_W'(TAPS))
        begin
            val = COEF_TABLE[phase][tap];
        end
        return val;
    endfunction

endpackage

/* hdl/pr32_taps.sv */
`timescale 1ns / 1ps
// ============================================================================
// pr32_taps
// Input delay line of the resampler: shifts in one sample per transaction and
// serves one tap per cycle by age, zero when the read is not enabled.
// ============================================================================
module pr32_taps #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pr32_pkg::taps_ctrl_t     ctrl,
    input  logic [SAMPLE_BITS-1:0]   shift_data,
    output logic [SAMPLE_BITS-1:0]   rd_data
);

    logic [SAMPLE_BITS-1:0] line_reg [pr32_pkg::TAPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pr32_pkg::TAPS; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < pr32_pkg::TAPS; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (ctrl.shift)
        begin
            for (int i = pr32_pkg::TAPS - 1; i > 0; i--)
            begin
                line_reg[i] <= line_reg[i-1];
            end
            line_reg[0] <= shift_data;
        end
    end

    assign rd_data = ctrl.rd_en ? line_reg[ctrl.rd_age] : '0;

endmodule

/* hdl/pr32_mac.sv */
`timescale 1ns / 1ps
// ============================================================================
// pr32_mac
// Shared multiply-accumulate unit: one tap product per cycle, a registered
// accumulator, then rounding and saturation of the finished sum.
// ============================================================================
module pr32_mac #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pr32_pkg::mac_ctrl_t      ctrl,
    input  logic [SAMPLE_BITS-1:0]   sample,
    output logic [SAMPLE_BITS-1:0]   y,
    output logic                     clip
);

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + pr32_pkg::GUARD_BITS;
    localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(1 << (COEF_BITS - 2));
    localparam logic signed [ACC_W-1:0] Y_HI      = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] Y_LO      = ~Y_HI;

    logic signed [pr32_pkg::ROM_BITS-1:0] rom_val;
    logic signed [COEF_BITS-1:0]          coef;
    logic signed [SAMPLE_BITS-1:0]        sample_s;
    logic signed [PROD_W-1:0]             prod_reg;
    logic                                 prod_valid_reg;
    logic signed [ACC_W-1:0]              acc_reg;
    logic signed [ACC_W-1:0]              rsum;
    logic signed [ACC_W-1:0]              yfull;
    logic [SAMPLE_BITS-1:0]               y_next;
    logic                                 clip_next;
    logic [SAMPLE_BITS-1:0]               y_reg;
    logic                                 clip_reg;

    assign rom_val  = pr32_pkg::coef_rom(ctrl.phase, ctrl.tap);
    assign sample_s = $signed(sample);

    generate
        if (COEF_BITS >= pr32_pkg::ROM_BITS)
        begin : g_widen
            assign coef = COEF_BITS'(rom_val) <<< (COEF_BITS - pr32_pkg::ROM_BITS);
        end
        else
        begin : g_narrow
            localparam int DROP = pr32_pkg::ROM_BITS - COEF_BITS;
            logic signed [pr32_pkg::ROM_BITS:0] rounded;
            assign rounded = (pr32_pkg::ROM_BITS + 1)'(rom_val)
                           + (pr32_pkg::ROM_BITS + 1)'(1 << (DROP - 1));
            assign coef    = $signed(rounded[DROP +: COEF_BITS]);
        end
    endgenerate

    always_comb
    begin
        rsum      = acc_reg + ROUND_ADD;
        yfull     = rsum >>> (COEF_BITS - 1);
        clip_next = 1'b0;
        y_next    = yfull[SAMPLE_BITS-1:0];
        if (yfull > Y_HI)
        begin
            y_next    = Y_HI[SAMPLE_BITS-1:0];
            clip_next = 1'b1;
        end
        else if (yfull < Y_LO)
        begin
            y_next    = Y_LO[SAMPLE_BITS-1:0];
            clip_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= ctrl.issue;
            if (ctrl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_valid_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= sample_s * coef;
        if (ctrl.round)
        begin
            y_reg    <= y_next;
            clip_reg <= clip_next;
        end
    end

    assign y    = y_reg;
    assign clip = clip_reg;

endmodule

/* hdl/polyphase_resampler_3_to_2_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// polyphase_resampler_3_to_2_top
// 24 kHz to 16 kHz polyphase windowed-sinc resampler, two phases of 23 taps.
// ============================================================================
// Input channel (feed_valid / feed_stall): one sample per transaction, with
// end_of_stream on the last sample of a stream. Output channel (result_valid
// / result_stall): one resampled sample per transaction, final_output on the
// last one of a stream, clipped when the rounded sum saturated.
// Every third input from the thirteenth on produces two outputs; the end of
// stream flushes the pending outputs (at most 12) and clears the block.
// One shared multiplier-accumulator runs 23 taps per output. An input that
// produces no output passes through the check state alone; each output takes
// a setup check, the 23 taps, the pipeline drain and the hand-off.
// feed_stall is high from acceptance until the cycle after the last output of
// that input has been loaded into the output register.
// Reset clears the delay line, the counters and the output register. A
// stalled result holds in the output register; the block waits in front of
// it with the next result and takes no input meanwhile.
// ============================================================================
module polyphase_resampler_3_to_2_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18,
    parameter int COUNT_BITS  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                feed_valid,
    output logic                feed_stall,
    input  logic signed [15:0]  sample_in,
    input  logic                end_of_stream,
    output logic                result_valid,
    input  logic                result_stall,
    output logic signed [15:0]  sample_out,
    output logic                final_output,
    output logic                clipped
);

    localparam int TRI_W = COUNT_BITS + 1;
    localparam int K3_W  = COUNT_BITS + 2;
    localparam int AGE_W = COUNT_BITS + 3;
    localparam int TAP_W = pr32_pkg::TAP_W;
    localparam int CNT_W = pr32_pkg::CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MAC,
        ST_PUSH
    } state_t;

    state_t                  state_reg,        state_next;
    logic [COUNT_BITS-1:0]   in_index_reg,     in_index_next;
    logic [COUNT_BITS-1:0]   out_index_reg,    out_index_next;
    logic [TRI_W-1:0]        tri_reg,          tri_next;
    logic [K3_W-1:0]         k3_reg,           k3_next;
    logic                    eos_reg,          eos_next;
    logic [CNT_W-1:0]        count_reg,        count_next;
    logic [TAP_W-1:0]        tap_reg,          tap_next;
    logic [AGE_W-1:0]        age_reg,          age_next;
    logic                    result_valid_reg, result_valid_next;
    logic [15:0]             sample_out_reg,   sample_out_next;
    logic                    final_reg,        final_next;
    logic                    clipped_reg,      clipped_next;

    logic                    emit;
    logic                    age_ok;
    logic                    slot_free;
    logic [AGE_W-1:0]        age_base;
    logic [SAMPLE_BITS-1:0]  feed_sample;
    logic [SAMPLE_BITS-1:0]  tap_sample;
    logic [SAMPLE_BITS-1:0]  mac_y;
    logic                    mac_clip;
    pr32_pkg::mac_ctrl_t     mac_ctrl;
    pr32_pkg::taps_ctrl_t    taps_ctrl;

    assign feed_sample = SAMPLE_BITS'($unsigned(sample_in));
    assign slot_free   = !result_valid_reg || !result_stall;

    assign emit = (count_reg < CNT_W'(pr32_pkg::MAX_RESULTS))
               && (eos_reg ? (k3_reg < {1'b0, in_index_reg, 1'b0})
                           : (({1'b0, tri_reg} + K3_W'(pr32_pkg::LAG))
                              <= {2'b0, in_index_reg}));

    assign age_base = {3'b0, in_index_reg} + AGE_W'(pr32_pkg::AGE_OFFSET)
                    - {2'b0, tri_reg};
    assign age_ok   = !age_reg[AGE_W-1] && (age_reg < AGE_W'(pr32_pkg::TAPS));

    always_comb
    begin
        mac_ctrl.clear = (state_reg == ST_CHECK) && emit;
        mac_ctrl.issue = (state_reg == ST_MAC) && (tap_reg < TAP_W'(pr32_pkg::TAPS));
        mac_ctrl.round = (state_reg == ST_MAC) && (tap_reg == TAP_W'(pr32_pkg::ROUND_TAP));
        mac_ctrl.phase = out_index_reg[0];
        mac_ctrl.tap   = tap_reg;

        taps_ctrl.shift  = (state_reg == ST_IDLE) && feed_valid;
        taps_ctrl.clear  = (state_reg == ST_CHECK) && !emit && eos_reg;
        taps_ctrl.rd_en  = mac_ctrl.issue && age_ok;
        taps_ctrl.rd_age = age_reg[TAP_W-1:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        in_index_next     = in_index_reg;
        out_index_next    = out_index_reg;
        tri_next          = tri_reg;
        k3_next           = k3_reg;
        eos_next          = eos_reg;
        count_next        = count_reg;
        tap_next          = tap_reg;
        age_next          = age_reg;
        result_valid_next = result_valid_reg && result_stall;
        sample_out_next   = sample_out_reg;
        final_next        = final_reg;
        clipped_next      = clipped_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (feed_valid)
                begin
                    if (in_index_reg != '1)
                    begin
                        in_index_next = in_index_reg + COUNT_BITS'(1);
                    end
                    eos_next   = end_of_stream;
                    count_next = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (emit)
                begin
                    age_next   = age_base;
                    tap_next   = '0;
                    state_next = ST_MAC;
                end
                else
                begin
                    if (eos_reg)
                    begin
                        in_index_next  = '0;
                        out_index_next = '0;
                        tri_next       = '0;
                        k3_next        = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_MAC:
            begin
                tap_next = tap_reg + TAP_W'(1);
                if (mac_ctrl.issue)
                begin
                    age_next = age_reg - AGE_W'(1);
                end
                if (mac_ctrl.round)
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (out_index_reg != '1)
                    begin
                        out_index_next = out_index_reg + COUNT_BITS'(1);
                        k3_next        = k3_reg + K3_W'(3);
                        if (out_index_reg[0])
                        begin
                            tri_next = tri_reg + TRI_W'(3);
                        end
                    end
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (slot_free)
                begin
                    result_valid_next = 1'b1;
                    sample_out_next   = 16'(mac_y);
                    clipped_next      = mac_clip;
                    final_next        = eos_reg && !emit;
                    state_next        = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            in_index_reg     <= '0;
            out_index_reg    <= '0;
            tri_reg          <= '0;
            k3_reg           <= '0;
            eos_reg          <= 1'b0;
            count_reg        <= '0;
            tap_reg          <= '0;
            age_reg          <= '0;
            result_valid_reg <= 1'b0;
            sample_out_reg   <= '0;
            final_reg        <= 1'b0;
            clipped_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            in_index_reg     <= in_index_next;
            out_index_reg    <= out_index_next;
            tri_reg          <= tri_next;
            k3_reg           <= k3_next;
            eos_reg          <= eos_next;
            count_reg        <= count_next;
            tap_reg          <= tap_next;
            age_reg          <= age_next;
            result_valid_reg <= result_valid_next;
            sample_out_reg   <= sample_out_next;
            final_reg        <= final_next;
            clipped_reg      <= clipped_next;
        end
    end

    pr32_taps #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_taps (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (taps_ctrl),
        .shift_data (feed_sample),
        .rd_data    (tap_sample)
    );

    pr32_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .sample (tap_sample),
        .y      (mac_y),
        .clip   (mac_clip)
    );

    assign feed_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign sample_out   = $signed(sample_out_reg);
    assign final_output = final_reg;
    assign clipped      = clipped_reg;

    a_k3_tracks_index: assert property (@(posedge clk) disable iff (!rst_n)
        k3_reg == ({2'b0, out_index_reg} + {1'b0, out_index_reg, 1'b0}))
        else $error("k3_reg out of step with out_index_reg");

    a_tri_tracks_block: assert property (@(posedge clk) disable iff (!rst_n)
        tri_reg == ({2'b0, out_index_reg[COUNT_BITS-1:1]}
                  + {1'b0, out_index_reg[COUNT_BITS-1:1], 1'b0}))
        else $error("tri_reg out of step with output block");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(pr32_pkg::MAX_RESULTS))
        else $error("too many results for one transaction");

    a_steady_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && emit && !eos_reg)
        |=> (age_reg == AGE_W'(pr32_pkg::TAPS - 1)))
        else $error("steady-state tap window misaligned");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && !emit && eos_reg)
        |=> (in_index_reg == '0 && out_index_reg == '0 && state_reg == ST_IDLE))
        else $error("end of stream did not clear the counters");

endmodule

/* tb/tb_polyphase_resampler_3_to_2_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_polyphase_resampler_3_to_2_top
// Self-checking bench for the 3:2 polyphase resampler. A scoreboard class
// holds its own delay line, counters and Q1.17 kernel. It works out the
// output samples that each accepted input transaction releases, including the
// flush at end of stream. Each output transaction is compared field by field
// with the oldest expected sample. Short streams and full-scale steps run
// first with no idling or stalls, random streams under four idle/stall mixes.
// A long receiver hold-off fills the block until it stalls its input.
// ============================================================================
module tb_polyphase_resampler_3_to_2_top;

    localparam int          NUM_TAPS    = 23;
    localparam int          MAX_OUT     = 12;
    localparam int          PHASE_ITEMS = 34;
    localparam longint unsigned CNT_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam logic signed [15:0] FS_POS = 16'sh7FFF;
    localparam logic signed [15:0] FS_NEG = 16'sh8000;

    localparam int KERNEL [2][NUM_TAPS] = '{
        '{ 0, 0, -141, 692, -226, -2847, 5603, -659, -15592, 35469, 86508,
           35469, -15592, -659, 5603, -2847, -226, 692, -141, 0, 0, 0, 0 },
        '{ 0, 0, 0, -48, 64, 950, -2353, 443, 6672, -12263, 816, 71288,
           71288, 816, -12263, 6672, 443, -2353, 950, 64, -48, 0, 0 }
    };

    typedef struct {
        logic signed [15:0] smp;
        logic               fin;
        logic               clip;
    } out_sample_t;

    class resample_scoreboard;
        logic signed [15:0] hist [NUM_TAPS];
        longint unsigned    taken;
        longint unsigned    given;
        out_sample_t        pending_samples [$];
        int                 errors;
        int                 checked;

        function new();
            errors  = 0;
            checked = 0;
            clear_state();
        endfunction

        function void clear_state();
            foreach (hist[i])
            begin
                hist[i] = '0;
            end
            taken = 0;
            given = 0;
        endfunction

        function out_sample_t filter_output();
            out_sample_t r;
            longint      blk;
            longint      age;
            longint      acc;
            longint      y;
            int          ph;
            blk    = longint'(given >> 1);
            ph     = int'(given & 1);
            acc    = 0;
            r.fin  = 1'b0;
            r.clip = 1'b0;
            for (int tap = 0; tap < NUM_TAPS; tap++)
            begin
                age = longint'(taken) + 9 - 3 * blk - tap;
                if (age >= 0 && age < NUM_TAPS)
                begin
                    acc += longint'(hist[age]) * longint'(KERNEL[ph][tap]);
                end
            end
            y = (acc + 65536) >>> 17;
            if (y > 32767)
            begin
                y      = 32767;
                r.clip = 1'b1;
            end
            if (y < -32768)
            begin
                y      = -32768;
                r.clip = 1'b1;
            end
            r.smp = y[15:0];
            return r;
        endfunction

        function void take_sample(logic signed [15:0] smp, logic eos);
            int              n;
            longint unsigned goal;
            longint unsigned need;
            for (int i = NUM_TAPS - 1; i > 0; i--)
            begin
                hist[i] = hist[i-1];
            end
            hist[0] = smp;
            if (taken < CNT_MAX)
            begin
                taken++;
            end
            goal = (2 * taken + 2) / 3;
            n    = 0;
            while (n < MAX_OUT)
            begin
                need = 3 * (given >> 1) + 12;
                if (eos)
                begin
                    if (given >= goal)
                    begin
                        break;
                    end
                end
                else if (need + 1 > taken)
                begin
                    break;
                end
                pending_samples = {pending_samples, filter_output()};
                n++;
                if (given < CNT_MAX)
                begin
                    given++;
                end
            end
            if (eos)
            begin
                if (n > 0)
                begin
                    pending_samples[pending_samples.size() - 1].fin = 1'b1;
                end
                clear_state();
            end
        endfunction

        function void match_output(logic signed [15:0] smp, logic fin, logic clip);
            out_sample_t e;
            if (pending_samples.size() == 0)
            begin
                $display("%0t ERROR: unexpected output sample=%0d final=%0b clipped=%0b",
                         $time, smp, fin, clip);
                errors++;
                return;
            end
            e = pending_samples.pop_front();
            checked++;
            if (smp !== e.smp)
            begin
                $display("%0t ERROR: sample_out expected %0d actual %0d", $time, e.smp, smp);
                errors++;
            end
            if (fin !== e.fin)
            begin
                $display("%0t ERROR: final_output expected %0b actual %0b", $time, e.fin, fin);
                errors++;
            end
            if (clip !== e.clip)
            begin
                $display("%0t ERROR: clipped expected %0b actual %0b", $time, e.clip, clip);
                errors++;
            end
        endfunction

        function void report_leftover();
            if (pending_samples.size() != 0)
            begin
                $display("%0t ERROR: %0d expected output samples never arrived",
                         $time, pending_samples.size());
                errors++;
            end
        endfunction
    endclass

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               feed_valid    = 1'b0;
    logic               feed_stall;
    logic signed [15:0] sample_in     = '0;
    logic               end_of_stream = 1'b0;
    logic               result_valid;
    logic               result_stall  = 1'b0;
    logic signed [15:0] sample_out;
    logic               final_output;
    logic               clipped;

    resample_scoreboard sb;
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 hold_request   = 0;
    int                 items_sent     = 0;

    polyphase_resampler_3_to_2_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .feed_valid    (feed_valid),
        .feed_stall    (feed_stall),
        .sample_in     (sample_in),
        .end_of_stream (end_of_stream),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .sample_out    (sample_out),
        .final_output  (final_output),
        .clipped       (clipped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_item(input logic signed [15:0] smp, input logic eos);
        feed_valid    <= 1'b1;
        sample_in     <= smp;
        end_of_stream <= eos;
        do
        begin
            @(posedge clk);
        end
        while (feed_stall);
        sb.take_sample(smp, eos);
        items_sent++;
        if (int'($urandom_range(99)) < send_idle_pct)
        begin
            feed_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_stream(input int len);
        logic signed [15:0] smp;
        int                 mode;
        for (int i = 0; i < len; i++)
        begin
            mode = int'($urandom_range(9));
            if (mode < 6)
            begin
                smp = 16'($urandom);
            end
            else if (mode < 8)
            begin
                smp = ($urandom_range(1) != 0) ? FS_POS : FS_NEG;
            end
            else
            begin
                smp = 16'(int'($urandom_range(0, 2000)) - 1000);
            end
            send_item(smp, i == len - 1);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int hold);
        int start;
        int len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        hold_request   = hold;
        start          = items_sent;
        while (items_sent - start < PHASE_ITEMS)
        begin
            if ($urandom_range(9) < 2)
            begin
                len = int'($urandom_range(1, 12));
            end
            else
            begin
                len = int'($urandom_range(13, 40));
            end
            if (len > PHASE_ITEMS - (items_sent - start))
            begin
                len = PHASE_ITEMS - (items_sent - start);
            end
            send_stream(len);
        end
    endtask

    // receiver: check each output transaction, then pick the next stall
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                sb.match_output(sample_out, final_output, clipped);
            end
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                result_stall <= (int'($urandom_range(99)) < recv_stall_pct);
            end
        end
    end

    initial
    begin
        int guard;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-sample stream, three-sample stream, full-scale step from positive to negative
        send_item(FS_POS, 1'b1);
        send_item(FS_NEG, 1'b0);
        send_item(16'sh0000, 1'b0);
        send_item(FS_POS, 1'b1);
        for (int i = 0; i < 20; i++)
        begin
            send_item((i < 10) ? FS_POS : FS_NEG, i == 19);
        end

        run_phase(0, 0, 400);
        run_phase(63, 0, 0);
        run_phase(0, 63, 0);
        run_phase(37, 37, 0);

        feed_valid     <= 1'b0;
        recv_stall_pct = 0;
        guard          = 0;
        while (sb.pending_samples.size() != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        sb.report_leftover();

        $display("Summary: %0d input transactions, %0d output samples checked", items_sent,
                 sb.checked);
        $display("Covered short streams, full-scale steps, random streams, four idle/stall mixes");
        if (sb.errors == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
hdl/pr32_pkg.sv
hdl/pr32_taps.sv
hdl/pr32_mac.sv
hdl/polyphase_resampler_3_to_2_top.sv
tb/tb_polyphase_resampler_3_to_2_top.sv
